@@ rtl/core/fad_pkg.sv @@
// ----------------------------------------------------------------------------
// fad_pkg
// Shared widths, codes, command/status types and fixed-point helpers for the
// fractional allpass delay.
// ----------------------------------------------------------------------------
package fad_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int GAIN_W     = 16;
  localparam int FRAC_W     = 16;
  localparam int WHOLE_W    = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MUL_A_W    = SAMPLE_W + 1;
  localparam int MUL_B_W    = GAIN_W + 1;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int RND15_W    = PROD_W - 15;
  localparam int RND16_W    = PROD_W - 16;
  localparam int SUM_W      = SAMPLE_W + 4;
  localparam int TAP_W      = RND16_W;

  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_WHOLE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_FRACTION = 2'd2;

  localparam logic signed [SUM_W-1:0] S24_MAX = SUM_W'(8388607);
  localparam logic signed [SUM_W-1:0] S24_MIN = -SUM_W'(8388608);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_FB,
    ST_WRITE,
    ST_RD_A,
    ST_RD_B,
    ST_MUL_D,
    ST_TAP,
    ST_OUT
  } fad_state_t;

  typedef enum logic [1:0] {
    MUL_OP_FB,
    MUL_OP_DIFF,
    MUL_OP_W
  } mul_op_t;

  typedef struct packed {
    logic    load_in;
    logic    mul_en;
    mul_op_t mul_op;
    logic    write_line;
    logic    rd_a;
    logic    rd_b;
    logic    load_tap;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
  } dp_status_t;

  function automatic logic signed [RND15_W-1:0] rnd15(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + PROD_W'(1 << 14);
    return t[PROD_W-1:15];
  endfunction

  function automatic logic signed [RND16_W-1:0] rnd16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + PROD_W'(1 << 15);
    return t[PROD_W-1:16];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > S24_MAX) begin
      r = S24_MAX[SAMPLE_W-1:0];
    end else if (v < S24_MIN) begin
      r = S24_MIN[SAMPLE_W-1:0];
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/fad_in_if.sv @@
// ----------------------------------------------------------------------------
// fad_in_if
// Input sample channel: valid/ready with one signed sample per beat.
// ----------------------------------------------------------------------------
interface fad_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [fad_pkg::SAMPLE_W-1:0]     sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

@@ rtl/core/fad_out_if.sv @@
// ----------------------------------------------------------------------------
// fad_out_if
// Result sample channel: valid/ready with one signed sample per beat.
// ----------------------------------------------------------------------------
interface fad_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [fad_pkg::SAMPLE_W-1:0]     sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

@@ rtl/core/fad_ctrl.sv @@
// ----------------------------------------------------------------------------
// fad_ctrl
// Sequencer for one sample: feedback multiply, line write, two tap reads,
// interpolation, output scaling, then hand-off to the output register.
// ----------------------------------------------------------------------------
module fad_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  fad_pkg::dp_status_t status,
  output fad_pkg::dp_cmd_t    cmd
);
  import fad_pkg::*;

  fad_state_t state_r, state_nxt;
  logic       out_valid_r;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid && !status.busy) state_nxt = ST_MUL_FB;
      ST_MUL_FB: state_nxt = ST_WRITE;
      ST_WRITE:  state_nxt = ST_RD_A;
      ST_RD_A:   state_nxt = ST_RD_B;
      ST_RD_B:   state_nxt = ST_MUL_D;
      ST_MUL_D:  state_nxt = ST_TAP;
      ST_TAP:    state_nxt = ST_OUT;
      ST_OUT:    if (out_free) state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd.load_in    = 1'b0;
    cmd.mul_en     = 1'b0;
    cmd.mul_op     = MUL_OP_FB;
    cmd.write_line = 1'b0;
    cmd.rd_a       = 1'b0;
    cmd.rd_b       = 1'b0;
    cmd.load_tap   = 1'b0;
    cmd.load_out   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = !status.busy;
        cmd.load_in = in_valid && !status.busy;
      end
      ST_MUL_FB: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_OP_FB;
      end
      ST_WRITE: cmd.write_line = 1'b1;
      ST_RD_A:  cmd.rd_a = 1'b1;
      ST_RD_B:  cmd.rd_b = 1'b1;
      ST_MUL_D: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_OP_DIFF;
      end
      ST_TAP: begin
        cmd.load_tap = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_op   = MUL_OP_W;
      end
      ST_OUT: cmd.load_out = out_free;
    endcase
  end

endmodule

@@ rtl/core/fad_datapath.sv @@
// ----------------------------------------------------------------------------
// fad_datapath
// Delay line memory, pointers, shared multiplier, rounding/saturation and
// configuration registers, including the offset-mod-depth reduction.
// ----------------------------------------------------------------------------
module fad_datapath #(
  parameter int LINE_DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  fad_pkg::dp_cmd_t                       cmd,
  output fad_pkg::dp_status_t                    status,
  input  logic signed [fad_pkg::SAMPLE_W-1:0]    sample_in,
  output logic signed [fad_pkg::SAMPLE_W-1:0]    sample_out,
  input  logic                                   cfg_we,
  input  logic [fad_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [fad_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
  import fad_pkg::*;

  localparam int            AW     = $clog2(LINE_DEPTH);
  localparam logic [AW:0]   DEPTH_X = (AW + 1)'(LINE_DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(LINE_DEPTH - 1);
  localparam int            QP_W    = 2 * WHOLE_W;
  localparam int            QD_W    = WHOLE_W + AW + 1;
  localparam logic [WHOLE_W-1:0] DEPTH_RECIP = WHOLE_W'((1 << WHOLE_W) / LINE_DEPTH);
  localparam logic [QD_W-1:0]    DEPTH_QD    = QD_W'(LINE_DEPTH);

  logic signed [SAMPLE_W-1:0] mem [LINE_DEPTH];

  logic signed [GAIN_W-1:0]   gain_r;
  logic [FRAC_W-1:0]          frac_r;
  logic [WHOLE_W-1:0]         src_r;
  logic [AW-1:0]              dmod_r;
  logic [WHOLE_W-1:0]         q_r;
  logic                       quot_pend_r;
  logic                       rem_pend_r;

  logic [AW-1:0]              wp_r;
  logic                       full_r;
  logic signed [SAMPLE_W-1:0] last_tap_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [SAMPLE_W-1:0] w_r;
  logic signed [SAMPLE_W-1:0] a_r;
  logic signed [SAMPLE_W-1:0] rd_r;
  logic signed [SAMPLE_W-1:0] out_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic [AW-1:0]              idx_r;
  logic                       va_r;
  logic                       vb_r;

  logic                       whole_wr;
  logic [QP_W-1:0]            qp_c;
  logic [WHOLE_W-1:0]         q_c;
  logic [QD_W-1:0]            qd_c;
  logic [WHOLE_W-1:0]         r_c;
  logic [AW-1:0]              rem_c;
  logic [AW:0]                sum_c;
  logic [AW-1:0]              i_c;
  logic [AW-1:0]              j_c;
  logic [AW-1:0]              rd_addr;
  logic signed [SAMPLE_W-1:0] b_c;
  logic signed [MUL_A_W-1:0]  diff_c;
  logic signed [MUL_A_W-1:0]  ma;
  logic signed [MUL_B_W-1:0]  mb;
  logic signed [PROD_W-1:0]   prod_c;
  logic signed [SAMPLE_W-1:0] w_c;
  logic signed [TAP_W-1:0]    tap_c;
  logic signed [SAMPLE_W-1:0] y_c;

  // unwritten entries read as zero: before the first wrap only 1..wp hold data
  function automatic logic line_valid(input logic [AW-1:0] idx, input logic [AW-1:0] wp,
                                      input logic full);
    return full || ((idx != '0) && (idx <= wp));
  endfunction

  assign whole_wr    = cfg_we && (cfg_index == CFG_DELAY_WHOLE);
  assign status.busy = quot_pend_r || rem_pend_r;

  // delay_whole mod depth: reciprocal quotient estimate, then one corrective subtract
  assign qp_c  = QP_W'(src_r) * QP_W'(DEPTH_RECIP);
  assign q_c   = qp_c[QP_W-1:WHOLE_W];
  assign qd_c  = QD_W'(q_r) * DEPTH_QD;
  assign r_c   = src_r - qd_c[WHOLE_W-1:0];
  assign rem_c = (QD_W'(r_c) >= DEPTH_QD) ? AW'(QD_W'(r_c) - DEPTH_QD) : AW'(r_c);

  assign sum_c   = {1'b0, wp_r} + {1'b0, dmod_r};
  assign i_c     = (sum_c >= DEPTH_X) ? AW'(sum_c - DEPTH_X) : sum_c[AW-1:0];
  assign j_c     = (idx_r == LAST) ? '0 : idx_r + 1'b1;
  assign rd_addr = cmd.rd_b ? j_c : i_c;

  assign b_c    = vb_r ? rd_r : '0;
  assign diff_c = MUL_A_W'(b_c) - MUL_A_W'(a_r);

  always_comb begin
    unique case (cmd.mul_op)
      MUL_OP_DIFF: begin
        ma = diff_c;
        mb = {1'b0, frac_r};
      end
      MUL_OP_W: begin
        ma = MUL_A_W'(w_r);
        mb = MUL_B_W'(gain_r);
      end
      default: begin
        ma = MUL_A_W'(last_tap_r);
        mb = MUL_B_W'(gain_r);
      end
    endcase
  end

  assign prod_c = ma * mb;

  assign w_c   = sat24(SUM_W'(x_r) + SUM_W'(rnd15(prod_r)));
  assign tap_c = TAP_W'(a_r) + rnd16(prod_r);
  assign y_c   = sat24(SUM_W'(last_tap_r) - SUM_W'(rnd15(prod_r)));

  assign sample_out = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= '0;
      frac_r      <= '0;
      src_r       <= '0;
      dmod_r      <= '0;
      q_r         <= '0;
      quot_pend_r <= 1'b0;
      rem_pend_r  <= 1'b0;
      wp_r        <= '0;
      full_r      <= 1'b0;
      last_tap_r  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FEEDBACK_GAIN:  gain_r <= cfg_wdata[GAIN_W-1:0];
          CFG_DELAY_WHOLE:    src_r  <= cfg_wdata[WHOLE_W-1:0];
          CFG_DELAY_FRACTION: frac_r <= cfg_wdata[FRAC_W-1:0];
          default: ;
        endcase
      end
      quot_pend_r <= whole_wr;
      rem_pend_r  <= quot_pend_r && !whole_wr;
      if (quot_pend_r) begin
        q_r <= q_c;
      end
      if (rem_pend_r) begin
        dmod_r <= rem_c;
      end
      if (cmd.load_in) begin
        wp_r <= (wp_r == LAST) ? '0 : wp_r + 1'b1;
        if (wp_r == LAST) begin
          full_r <= 1'b1;
        end
      end
      if (cmd.load_tap) begin
        last_tap_r <= tap_c[SAMPLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r <= sample_in;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_c;
    end
    if (cmd.write_line) begin
      w_r <= w_c;
    end
    if (cmd.rd_a) begin
      idx_r <= i_c;
      va_r  <= line_valid(i_c, wp_r, full_r);
    end
    if (cmd.rd_b) begin
      vb_r <= line_valid(j_c, wp_r, full_r);
      a_r  <= va_r ? rd_r : '0;
    end
    if (cmd.load_out) begin
      out_r <= y_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_line) begin
      mem[wp_r] <= w_c;
    end
    rd_r <= mem[rd_addr];
  end

endmodule

@@ rtl/core/fractional_allpass_delay.sv @@
// The sequencer passes each sample through the single line read port and the
// shared multiplier step by step, so a new input sample is accepted only once
// the previous one has been handed to a free output register. A write to
// delay_whole blocks input while the offset is reduced mod depth. Reset
// (synchronous, rst_n low) clears the state, configuration registers and
// pointers; the line reads as zero until written, without a clearing pass.
// ----------------------------------------------------------------------------
// fractional_allpass_delay
// Schroeder allpass section with a linearly interpolated fractional tap.
// ----------------------------------------------------------------------------
module fractional_allpass_delay #(
  parameter int LINE_DEPTH = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  fad_in_if.sink                               in_ch,
  fad_out_if.source                            out_ch,
  input  logic                                 cfg_we,
  input  logic [fad_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fad_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import fad_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  fad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  fad_datapath #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .sample_in  (in_ch.sample_in),
    .sample_out (out_ch.sample_out),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input beat accepted while a sample is in flight");

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(in_ch.valid && in_ch.ready, 8))
    else $error("result beat does not follow its input beat by the fixed latency");

  a_reduce_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index == CFG_DELAY_WHOLE) |=> !in_ch.ready)
    else $error("input accepted during offset reduction");

endmodule

@@ test/tb_fractional_allpass_delay.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fractional_allpass_delay
// Self-checking bench for the fractional allpass delay. Samples are streamed
// through the valid/ready channels under changing tap settings and handshake
// pressure. A scoreboard keeps its own copy of the delay line and compares
// every output beat with the predicted allpass sample, in order.
// ----------------------------------------------------------------------------
module tb_fractional_allpass_delay;
  import fad_pkg::*;

  localparam int LINE_DEPTH      = 4096;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int PRESSURE_PHASE  = 4;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 16;
  localparam int STALL_LIMIT     = 3000;

  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;
  localparam logic [GAIN_W-1:0]          GAIN_MINUS_ONE = 16'h8000;
  localparam logic [GAIN_W-1:0]          GAIN_MAX       = 16'h7FFF;

  localparam int IDLE_PCTS  [4] = '{0, 56, 0, 20};
  localparam int STALL_PCTS [4] = '{0, 0, 56, 20};

  class allpass_scoreboard;
    logic signed [SAMPLE_W-1:0] line_mem [LINE_DEPTH];
    int                         wr_ptr;
    logic signed [SAMPLE_W-1:0] prev_tap;
    logic signed [GAIN_W-1:0]   gain;
    logic [WHOLE_W-1:0]         whole;
    logic [FRAC_W-1:0]          frac;
    logic signed [SAMPLE_W-1:0] expected_q [$];
    int                         errors;

    function void clear_state();
      foreach (line_mem[k]) line_mem[k] = '0;
      wr_ptr   = 0;
      prev_tap = '0;
      gain     = '0;
      whole    = '0;
      frac     = '0;
      errors   = 0;
      expected_q.delete();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_FEEDBACK_GAIN:  gain  = value;
        CFG_DELAY_WHOLE:    whole = value[WHOLE_W-1:0];
        CFG_DELAY_FRACTION: frac  = value;
        default: ;
      endcase
    endfunction

    // round half up after the Q1.15 gain product
    function longint times_gain(longint x);
      return (x * longint'(gain) + 64'sd16384) >>> 15;
    endfunction

    function logic signed [SAMPLE_W-1:0] clamp(longint v);
      if (v > 64'sd8388607) begin
        return SAMPLE_MAX;
      end else if (v < -64'sd8388608) begin
        return SAMPLE_MIN;
      end
      return v[SAMPLE_W-1:0];
    endfunction

    function void note_input(logic signed [SAMPLE_W-1:0] x);
      int                         i;
      int                         j;
      longint                     a;
      longint                     b;
      longint                     tap;
      logic signed [SAMPLE_W-1:0] w;
      wr_ptr = (wr_ptr + 1) % LINE_DEPTH;
      w = clamp(longint'(x) + times_gain(longint'(prev_tap)));
      line_mem[wr_ptr] = w;
      i = (wr_ptr + int'(whole)) % LINE_DEPTH;
      j = (i + 1) % LINE_DEPTH;
      a = longint'(line_mem[i]);
      b = longint'(line_mem[j]);
      tap = a + (((b - a) * longint'(frac) + 64'sd32768) >>> 16);
      prev_tap = tap[SAMPLE_W-1:0];
      expected_q.push_back(clamp(tap - times_gain(longint'(w))));
    endfunction

    function void check_output(logic signed [SAMPLE_W-1:0] got);
      logic signed [SAMPLE_W-1:0] want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual sample_out %0d", $time, got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: sample_out expected %0d, actual %0d", $time, want, got);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fad_in_if  in_ch ();
  fad_out_if out_ch ();

  fractional_allpass_delay #(
    .LINE_DEPTH(LINE_DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  allpass_scoreboard allpass = new();
  int                idle_pct = 0;
  int                stall_pct = 0;
  bit                hold_req = 1'b0;
  int                quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      allpass.check_output(out_ch.sample_out);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return SAMPLE_W'($urandom_range(0, 1023)) - SAMPLE_W'(512);
      default: return r[SAMPLE_W-1:0];
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return GAIN_MINUS_ONE;
      1:       return GAIN_MAX;
      2:       return '0;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_whole();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CFG_DATA_W'(LINE_DEPTH - 1);
      2, 3:    return CFG_DATA_W'($urandom_range(0, LINE_DEPTH - 1));
      default: return CFG_DATA_W'($urandom_range(0, 31));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_fraction();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    allpass.write_reg(idx, value);
    @(negedge clk);
  endtask

  // only called with the block idle
  task automatic program_taps(input logic [CFG_DATA_W-1:0] g, input logic [CFG_DATA_W-1:0] wh,
                              input logic [CFG_DATA_W-1:0] fr);
    cfg_beat(CFG_FEEDBACK_GAIN, g);
    cfg_beat(CFG_DELAY_WHOLE, wh);
    cfg_beat(CFG_DELAY_FRACTION, fr);
    cfg_beat(CFG_NO_REG, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= x;
    do @(posedge clk); while (!in_ch.ready);
    allpass.note_input(x);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (allpass.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] wrap_whole;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_FEEDBACK_GAIN;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    allpass.clear_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: zero offset and fraction, tap is the sample just written
    send_sample(24'sh000000);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(-24'sd1);
    send_sample(24'sd1);
    send_sample(24'sh555555);
    send_sample(24'shAAAAAA);

    // gain of minus one, largest offset (the tap index wraps past the end of the line), half fraction
    drain();
    program_taps(GAIN_MINUS_ONE, CFG_DATA_W'(LINE_DEPTH - 1), 16'h8000);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    send_sample(24'sh000000);
    send_sample(24'sh123456);

    // first tap on the last entry, second tap wraps to entry zero
    drain();
    wrap_whole = CFG_DATA_W'((2 * LINE_DEPTH - 2 - allpass.wr_ptr) % LINE_DEPTH);
    program_taps(GAIN_MAX, wrap_whole, 16'hFFFF);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(24'sh7FF000);

    drain();
    program_taps(16'h4000, 16'd2, 16'h0000);
    repeat (5) send_sample(pick_sample());

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      program_taps(pick_gain(), pick_whole(), pick_fraction());
      idle_pct  = IDLE_PCTS[ph % 4];
      stall_pct = STALL_PCTS[ph % 4];
      if (ph == PRESSURE_PHASE) begin
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);
      end
      repeat (ITEMS_PER_PHASE) send_sample(pick_sample());
    end

    drain();
    if (allpass.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/fad_pkg.sv
rtl/core/fad_in_if.sv
rtl/core/fad_out_if.sv
rtl/core/fad_ctrl.sv
rtl/core/fad_datapath.sv
rtl/core/fractional_allpass_delay.sv
test/tb_fractional_allpass_delay.sv
